// ===== src/power_mode_state_machine_top_defines.svh =====
// ----------------------------------------------------------------------------
// power mode state machine assertion macros
// shared property wrappers for the rtl checks
// ----------------------------------------------------------------------------
`ifndef POWER_MODE_STATE_MACHINE_TOP_DEFINES_SVH
`define POWER_MODE_STATE_MACHINE_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PMSM_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pmsm check failed: same-cycle implication");

// next-cycle implication, disabled while in reset
`define PMSM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pmsm check failed: next-cycle implication");

`endif

// ===== src/pmsm_pkg.sv =====
// ----------------------------------------------------------------------------
// pmsm_pkg
// types, constants, microcode table and transition rules of the power mode fsm
// ----------------------------------------------------------------------------
`default_nettype none

package pmsm_pkg;

   localparam int MAX_CHAIN = 8;
   localparam int CHAIN_W   = $clog2(MAX_CHAIN);
   localparam int REQ_W     = 8;
   localparam int RSP_W     = 24;
   localparam int LIMIT_W   = 8;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   localparam logic [LIMIT_W-1:0] SAVE_LIMIT_RST = 8'd130;
   localparam logic [LIMIT_W-1:0] FULL_LIMIT_RST = 8'd255;

   typedef enum logic [2:0] {
      MODE_ACTIVE = 3'd0,
      MODE_SAVE   = 3'd1,
      MODE_SHUT   = 3'd2,
      MODE_SUSP   = 3'd3,
      MODE_CHRG   = 3'd4,
      MODE_HIB    = 3'd5
   } mode_type;

   typedef enum logic [0:0] {
      STEP_WAIT = 1'b0,
      STEP_EVAL = 1'b1
   } step_type;

   // one control word per sequencer step
   typedef struct packed {
      logic     wait_in;
      logic     wait_out;
      logic     load_item;
      logic     run_step;
      logic     jump_on_end;
      step_type next_step;
      step_type jump_step;
   } ucode_type;

   typedef struct packed {
      logic load;
      logic eval;
   } ctrl_type;

   typedef struct packed {
      logic out_free;
      logic chain_end;
   } stat_type;

   typedef struct packed {
      logic     move;
      mode_type nxt;
      logic     clr_on;
      logic     clr_hib;
      logic     clr_susp;
      logic     ship;
   } eval_type;

   function automatic ucode_type ucode_rom(step_type s);
      ucode_type cw;
      case (s)
         STEP_WAIT: begin
            cw = '{wait_in: 1'b1, wait_out: 1'b0, load_item: 1'b1, run_step: 1'b0,
                   jump_on_end: 1'b0, next_step: STEP_EVAL, jump_step: STEP_WAIT};
         end
         STEP_EVAL: begin
            cw = '{wait_in: 1'b0, wait_out: 1'b1, load_item: 1'b0, run_step: 1'b1,
                   jump_on_end: 1'b1, next_step: STEP_EVAL, jump_step: STEP_WAIT};
         end
         default: begin
            cw = '{wait_in: 1'b0, wait_out: 1'b0, load_item: 1'b0, run_step: 1'b0,
                   jump_on_end: 1'b0, next_step: STEP_WAIT, jump_step: STEP_WAIT};
         end
      endcase
      return cw;
   endfunction

   // rules of one mode, in priority order
   function automatic eval_type eval_rules(mode_type m, logic p_on, logic p_hib,
                                           logic p_susp, logic tl, logic usb,
                                           logic wl, logic low, logic crit);
      eval_type r;
      r = '{move: 1'b0, nxt: m, clr_on: 1'b0, clr_hib: 1'b0, clr_susp: 1'b0,
            ship: 1'b0};
      case (m)
         MODE_ACTIVE: begin
            if (p_hib) begin
               r.move = 1'b1; r.nxt = MODE_HIB; r.clr_hib = 1'b1;
            end else if (p_susp) begin
               r.move = 1'b1; r.nxt = MODE_SUSP; r.clr_susp = 1'b1;
            end else if (!usb && low) begin
               r.move = 1'b1; r.nxt = MODE_SAVE;
            end
         end
         MODE_SAVE: begin
            if (p_hib) begin
               r.move = 1'b1; r.nxt = MODE_HIB; r.clr_hib = 1'b1;
            end else if (p_susp) begin
               r.move = 1'b1; r.nxt = MODE_SUSP; r.clr_susp = 1'b1;
            end else if (usb || !low) begin
               r.move = 1'b1; r.nxt = MODE_ACTIVE;
            end else if (crit) begin
               r.move = 1'b1; r.nxt = MODE_SHUT;
            end
         end
         MODE_SHUT: begin
            if (p_hib) begin
               r.move = 1'b1; r.nxt = MODE_HIB; r.clr_hib = 1'b1;
            end else if (usb || !crit) begin
               r.move = 1'b1; r.nxt = MODE_SAVE;
            end else if (tl) begin
               r.move = 1'b1; r.nxt = MODE_HIB;
            end
         end
         MODE_SUSP: begin
            r.move = 1'b1; r.nxt = MODE_SAVE;
         end
         MODE_CHRG: begin
            if (p_on) begin
               r.move = 1'b1; r.nxt = MODE_SAVE; r.clr_on = 1'b1;
            end else if (!usb && !wl) begin
               r.move = 1'b1; r.nxt = MODE_HIB;
            end else if (p_hib) begin
               r.clr_hib = 1'b1;
            end
         end
         MODE_HIB: begin
            if (p_on) begin
               r.move = 1'b1; r.nxt = MODE_SAVE; r.clr_on = 1'b1;
            end else if (usb || wl) begin
               r.move = 1'b1; r.nxt = MODE_CHRG;
            end else if (p_hib) begin
               r.clr_hib = 1'b1; r.ship = 1'b1;
            end
         end
         default: begin
            r.move = 1'b0;
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/power_mode_state_machine_top.sv =====
// a result is registered by the evaluate step that follows its input transfer
// an item gives n results (n from 1 to 8), one per cycle unless the output stalls
// the results come from the microcoded loop, which takes one transition per result
// the next input transfer is taken in the cycle after the last result is registered
// reset: synchronous, active high; mode active, no requests pending, limits 130 and 255
// ----------------------------------------------------------------------------
// power_mode_state_machine_top
// six-mode power controller: csr block, microcode sequencer and datapath
// ----------------------------------------------------------------------------
`default_nettype none

module power_mode_state_machine_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // input item transfer
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // req_tdata from bit 0: turn_on_req, hibernate_req, suspend_req, usb_present,
   // wireless_present, batt_low, batt_critical, timer_done
   input  wire logic [pmsm_pkg::REQ_W-1:0]    req_tdata,
   // result transfer
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // rsp_tdata from bit 0: mode_now[2:0], changed, backlight_write,
   // backlight_cap[7:0], timer_start, timer_stop, do_suspend, ship_mode,
   // store_reboot, zero fill [23:18]
   output logic [pmsm_pkg::RSP_W-1:0]         rsp_tdata,
   output logic                               rsp_tlast,    // last result of the item
   // register port
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [pmsm_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [pmsm_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [pmsm_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                               csr_pready
);

   // backlight limit registers: save at address 0, full at address 4
   logic [pmsm_pkg::LIMIT_W-1:0] save_limit_ff, save_limit_in;
   logic [pmsm_pkg::LIMIT_W-1:0] full_limit_ff, full_limit_in;
   logic                         csr_wr;

   pmsm_pkg::ctrl_type ctrl;
   pmsm_pkg::stat_type stat;

   assign csr_pready = 1'b1;

   always_comb begin
      // write completes on the access phase
      csr_wr        = csr_psel && csr_penable && csr_pwrite && csr_pready;
      save_limit_in = save_limit_ff;
      full_limit_in = full_limit_ff;
      if (csr_wr) begin
         // word select on address bit 2
         if (csr_paddr[2]) begin
            full_limit_in = csr_pwdata[pmsm_pkg::LIMIT_W-1:0];
         end else begin
            save_limit_in = csr_pwdata[pmsm_pkg::LIMIT_W-1:0];
         end
      end
      csr_prdata = '0;
      if (csr_paddr[2]) begin
         csr_prdata[pmsm_pkg::LIMIT_W-1:0] = full_limit_ff;
      end else begin
         csr_prdata[pmsm_pkg::LIMIT_W-1:0] = save_limit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         save_limit_ff <= pmsm_pkg::SAVE_LIMIT_RST;
         full_limit_ff <= pmsm_pkg::FULL_LIMIT_RST;
      end else begin
         save_limit_ff <= save_limit_in;
         full_limit_ff <= full_limit_in;
      end
   end

   // step counter and control table: wait for a transfer, then evaluate
   // one transition per cycle while the result register is free, until the chain ends
   pmsm_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctrl       (ctrl)
   );

   // mode, pending requests, timer latch and the result register
   pmsm_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .req_tdata  (req_tdata),
      .save_limit (save_limit_ff),
      .full_limit (full_limit_ff),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== src/pmsm_sequencer.sv =====
// ----------------------------------------------------------------------------
// pmsm_sequencer
// step counter over the microcode table, drives load and evaluate strobes
// ----------------------------------------------------------------------------
`default_nettype none

`include "power_mode_state_machine_top_defines.svh"

module pmsm_sequencer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire pmsm_pkg::stat_type  stat,
   output pmsm_pkg::ctrl_type       ctrl
);

   pmsm_pkg::step_type  step_ff;
   pmsm_pkg::step_type  step_in;
   pmsm_pkg::ucode_type cw;
   logic                go;

   always_comb begin
      cw = pmsm_pkg::ucode_rom(step_ff);
      go = (!cw.wait_in || req_tvalid) && (!cw.wait_out || stat.out_free);
      ctrl.load = go && cw.load_item;
      ctrl.eval = go && cw.run_step;
      req_tready = cw.wait_in;
      if (!go) begin
         step_in = step_ff;
      end else if (cw.jump_on_end && stat.chain_end) begin
         step_in = cw.jump_step;
      end else begin
         step_in = cw.next_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= pmsm_pkg::STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   `PMSM_ASSERT_NEXT(a_load_starts_eval, clock, reset, ctrl.load, step_ff == pmsm_pkg::STEP_EVAL)
   `PMSM_ASSERT_NEXT(a_end_returns_wait, clock, reset, ctrl.eval && stat.chain_end, step_ff == pmsm_pkg::STEP_WAIT)

endmodule

`default_nettype wire

// ===== src/pmsm_datapath.sv =====
// ----------------------------------------------------------------------------
// pmsm_datapath
// mode and pending registers, rule evaluation with one-step lookahead,
// result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "power_mode_state_machine_top_defines.svh"

module pmsm_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pmsm_pkg::ctrl_type            ctrl,
   input  wire logic [pmsm_pkg::REQ_W-1:0]    req_tdata,
   input  wire logic [pmsm_pkg::LIMIT_W-1:0]  save_limit,
   input  wire logic [pmsm_pkg::LIMIT_W-1:0]  full_limit,
   input  wire logic                          rsp_tready,
   output pmsm_pkg::stat_type                 stat,
   output logic                               rsp_tvalid,
   output logic [pmsm_pkg::RSP_W-1:0]         rsp_tdata,
   output logic                               rsp_tlast
);

   pmsm_pkg::mode_type                mode_ff, mode_in;
   logic                              pend_on_ff, pend_on_in;
   logic                              pend_hib_ff, pend_hib_in;
   logic                              pend_susp_ff, pend_susp_in;
   logic                              tlatch_ff, tlatch_in;
   logic [3:0]                        lvl_ff, lvl_in;     // usb, wireless, low, critical
   logic [pmsm_pkg::CHAIN_W-1:0]      cnt_ff, cnt_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [pmsm_pkg::RSP_W-1:0]        rsp_data_ff, rsp_data_in;
   logic                              rsp_last_ff, rsp_last_in;

   pmsm_pkg::eval_type                cur, look;
   logic                              on_a, hib_a, susp_a, tl_a;
   logic                              cap_end, hib_end, last, take_look;
   logic                              bl_write;
   logic [pmsm_pkg::LIMIT_W-1:0]      bl_cap;

   always_comb begin
      cur = pmsm_pkg::eval_rules(mode_ff, pend_on_ff, pend_hib_ff, pend_susp_ff, tlatch_ff,
                                 lvl_ff[0], lvl_ff[1], lvl_ff[2], lvl_ff[3]);
      on_a   = pend_on_ff & ~cur.clr_on;
      hib_a  = pend_hib_ff & ~cur.clr_hib;
      susp_a = pend_susp_ff & ~cur.clr_susp;
      // leaving shutting down drops the timer latch
      tl_a   = (cur.move && (mode_ff == pmsm_pkg::MODE_SHUT)) ? 1'b0 : tlatch_ff;
      // state the next step would see, to know whether this result is the last
      look = pmsm_pkg::eval_rules(cur.nxt, on_a, hib_a, susp_a, tl_a,
                                  lvl_ff[0], lvl_ff[1], lvl_ff[2], lvl_ff[3]);
      cap_end   = (cnt_ff == pmsm_pkg::CHAIN_W'(pmsm_pkg::MAX_CHAIN - 1));
      hib_end   = (cur.nxt == pmsm_pkg::MODE_HIB);
      last      = !cur.move || hib_end || cap_end || !look.move;
      take_look = cur.move && !hib_end && !cap_end && !look.move;

      bl_write = cur.move && ((cur.nxt == pmsm_pkg::MODE_ACTIVE) ||
                              (cur.nxt == pmsm_pkg::MODE_SAVE));
      if (!bl_write) begin
         bl_cap = '0;
      end else if (cur.nxt == pmsm_pkg::MODE_ACTIVE) begin
         bl_cap = full_limit;
      end else begin
         bl_cap = save_limit;
      end

      rsp_data_in        = '0;
      rsp_data_in[2:0]   = cur.nxt;
      rsp_data_in[3]     = cur.move;
      rsp_data_in[4]     = bl_write;
      rsp_data_in[12:5]  = bl_cap;
      rsp_data_in[13]    = cur.move && (cur.nxt == pmsm_pkg::MODE_SHUT);
      rsp_data_in[14]    = cur.move && (mode_ff == pmsm_pkg::MODE_SHUT);
      rsp_data_in[15]    = cur.move && (cur.nxt == pmsm_pkg::MODE_SUSP);
      rsp_data_in[16]    = !cur.move && cur.ship;
      rsp_data_in[17]    = cur.move && hib_end;
      rsp_last_in        = last;

      stat.out_free  = !rsp_valid_ff || rsp_tready;
      stat.chain_end = last;
   end

   // next state, driven by the sequencer strobes
   always_comb begin
      mode_in      = mode_ff;
      pend_on_in   = pend_on_ff;
      pend_hib_in  = pend_hib_ff;
      pend_susp_in = pend_susp_ff;
      tlatch_in    = tlatch_ff;
      lvl_in       = lvl_ff;
      cnt_in       = cnt_ff;
      if (ctrl.load) begin
         pend_on_in   = pend_on_ff | req_tdata[0];
         pend_hib_in  = pend_hib_ff | req_tdata[1];
         pend_susp_in = pend_susp_ff | req_tdata[2];
         lvl_in       = req_tdata[6:3];
         tlatch_in    = tlatch_ff | req_tdata[7];
         cnt_in       = '0;
      end else if (ctrl.eval) begin
         mode_in      = cur.nxt;
         pend_on_in   = on_a & ~(take_look & look.clr_on);
         pend_hib_in  = hib_a & ~(take_look & look.clr_hib);
         pend_susp_in = susp_a & ~(take_look & look.clr_susp);
         tlatch_in    = tl_a;
         cnt_in       = cnt_ff + pmsm_pkg::CHAIN_W'(cur.move);
      end

      if (ctrl.eval) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= pmsm_pkg::MODE_ACTIVE;
         pend_on_ff   <= 1'b0;
         pend_hib_ff  <= 1'b0;
         pend_susp_ff <= 1'b0;
         tlatch_ff    <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         pend_on_ff   <= pend_on_in;
         pend_hib_ff  <= pend_hib_in;
         pend_susp_ff <= pend_susp_in;
         tlatch_ff    <= tlatch_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff <= lvl_in;
      if (ctrl.eval) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `PMSM_ASSERT_NEXT(a_shut_exit_clears_timer, clock, reset, ctrl.eval && cur.move && (mode_ff == pmsm_pkg::MODE_SHUT), !tlatch_ff)
   `PMSM_ASSERT_NEXT(a_hib_entry_is_last, clock, reset, ctrl.eval && cur.move && hib_end, rsp_last_ff && rsp_valid_ff)

endmodule

`default_nettype wire
